// ----- rtl/ggf_pkg.sv -----
package ggf_pkg;

    // Fixed field widths of the request and result items
    localparam int NODE_W     = 6;
    localparam int SEQ_W      = 16;
    localparam int TTL_W      = 8;
    localparam int HOPS_W     = 8;
    localparam int COUNT_W    = 7;
    localparam int IN_COORD_W = 16;
    localparam int RANGE_W    = 33;
    localparam int ACTION_W   = 3;
    localparam int REQ_W      = 2;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 33;

    localparam logic [CFG_IDX_W-1:0] CFG_OWN_NODE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SINK_NODE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OWN_IS_SINK = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_SQ    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_START_TTL   = 3'd5;

    typedef enum logic [REQ_W-1:0] {
        REQ_WRITE = 2'd0,
        REQ_RECV  = 2'd1,
        REQ_GEN   = 2'd2
    } req_type_t;

    typedef enum logic [ACTION_W-1:0] {
        ACT_WRITTEN     = 3'd0,
        ACT_DELIVERED   = 3'd1,
        ACT_DROP_TTL    = 3'd2,
        ACT_DROP_NO_HOP = 3'd3,
        ACT_FORWARDED   = 3'd4
    } action_t;

    // Kind of squared-distance job in flight through the distance unit
    typedef enum logic [1:0] {
        DK_BASE  = 2'd0,
        DK_RANGE = 2'd1,
        DK_SINK  = 2'd2
    } dist_kind_t;

    typedef struct packed {
        logic       valid;
        dist_kind_t kind;
        logic       skip;
    } dist_tag_t;

    typedef enum logic [2:0] {
        S_IDLE    = 3'd0,
        S_OWN_RD  = 3'd1,
        S_SINK_RD = 3'd2,
        S_BASE    = 3'd3,
        S_SCAN    = 3'd4,
        S_DRAIN   = 3'd5
    } fsm_state_t;

endpackage

// ----- rtl/ggf_node_table.sv -----
module ggf_node_table #(
    parameter int DEPTH = 64,
    parameter int AW    = 6,
    parameter int EW    = 33
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [EW-1:0] wdata,
    input  logic [AW-1:0] raddr,
    output logic [EW-1:0] rdata
);

    logic [EW-1:0] mem [DEPTH];
    logic [EW-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port, reads every cycle
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/ggf_dist_unit.sv -----
module ggf_dist_unit #(
    parameter int CW = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  ggf_pkg::dist_tag_t    in_tag,
    input  logic [CW-1:0]         ax,
    input  logic [CW-1:0]         ay,
    input  logic [CW-1:0]         bx,
    input  logic [CW-1:0]         by,
    output ggf_pkg::dist_tag_t    out_tag,
    output logic [2*CW:0]         out_dist,
    output logic                  busy
);
    import ggf_pkg::*;

    localparam int SQ_W = 2 * CW;
    localparam int DW   = 2 * CW + 1;

    dist_tag_t       tag1_reg, tag2_reg, tag3_reg;
    logic [CW-1:0]   dx_reg, dy_reg;
    logic [CW-1:0]   dx_next, dy_next;
    logic [SQ_W-1:0] sqx_reg, sqy_reg;
    logic [DW-1:0]   sum_reg;

    // Stage 1: absolute coordinate differences
    always_comb
    begin
        dx_next = (ax > bx) ? ax - bx : bx - ax;
        dy_next = (ay > by) ? ay - by : by - ay;
    end

    // Tag pipeline, one job per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag1_reg <= '0;
            tag2_reg <= '0;
            tag3_reg <= '0;
        end
        else
        begin
            tag1_reg <= in_tag;
            tag2_reg <= tag1_reg;
            tag3_reg <= tag2_reg;
        end
    end

    // Datapath: diff, square, sum
    always_ff @(posedge clk)
    begin
        dx_reg  <= dx_next;
        dy_reg  <= dy_next;
        sqx_reg <= SQ_W'(dx_reg) * SQ_W'(dx_reg);
        sqy_reg <= SQ_W'(dy_reg) * SQ_W'(dy_reg);
        sum_reg <= DW'(sqx_reg) + DW'(sqy_reg);
    end

    assign out_tag  = tag3_reg;
    assign out_dist = sum_reg;
    assign busy     = tag1_reg.valid | tag2_reg.valid | tag3_reg.valid;

endmodule

// ----- rtl/greedy_geographic_forwarder_top.sv -----
// Channel | Handshake              | Payload
// --------+------------------------+------------------------------------------------
// in      | in_valid / in_ready    | req_type, entry_*, pkt_*
// out     | out_valid / out_ready  | action, next_hop, out_source, out_sequence,
//         |                        | out_ttl, out_hops
// cfg     | cfg_write (no wait)    | cfg_index, cfg_data
//
// Table write, delivery and TTL drop: item accepted, result valid the next cycle.
// Forwarding: n = min(node_count, MAX_NODES); the result is registered once the scan ends and
// the shared 3-stage distance unit drains; the scan issues two squared-distance jobs per entry.
// Reset clears control, configuration and the sequence counter; the node table is
// undefined until written and has no clearing pass.
// in_ready is low while an item is in work or a result waits untaken.
module greedy_geographic_forwarder_top #(
    parameter int MAX_NODES  = 64,
    parameter int COORD_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,

    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [ggf_pkg::REQ_W-1:0]           req_type,
    input  logic [ggf_pkg::NODE_W-1:0]          entry_index,
    input  logic [ggf_pkg::IN_COORD_W-1:0]      entry_x,
    input  logic [ggf_pkg::IN_COORD_W-1:0]      entry_y,
    input  logic                                entry_is_controller,
    input  logic [ggf_pkg::NODE_W-1:0]          pkt_source,
    input  logic [ggf_pkg::SEQ_W-1:0]           pkt_sequence,
    input  logic [ggf_pkg::NODE_W-1:0]          pkt_destination,
    input  logic [ggf_pkg::TTL_W-1:0]           pkt_ttl,
    input  logic [ggf_pkg::HOPS_W-1:0]          pkt_hops,

    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [ggf_pkg::ACTION_W-1:0]        action,
    output logic [ggf_pkg::NODE_W-1:0]          next_hop,
    output logic [ggf_pkg::NODE_W-1:0]          out_source,
    output logic [ggf_pkg::SEQ_W-1:0]           out_sequence,
    output logic [ggf_pkg::TTL_W-1:0]           out_ttl,
    output logic [ggf_pkg::HOPS_W-1:0]          out_hops,

    input  logic                                cfg_write,
    input  logic [ggf_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [ggf_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import ggf_pkg::*;

    localparam int CW    = COORD_BITS;
    localparam int DW    = 2 * CW + 1;
    localparam int CMP_W = (DW > RANGE_W) ? DW : RANGE_W;
    localparam int IDX_W = $clog2(MAX_NODES);
    localparam int CNT_W = $clog2(MAX_NODES + 1);
    localparam int EW    = 2 * CW + 1;

    // Configuration registers
    logic [NODE_W-1:0]  own_node_reg;
    logic [NODE_W-1:0]  sink_node_reg;
    logic               own_is_sink_reg;
    logic [COUNT_W-1:0] node_count_reg;
    logic [RANGE_W-1:0] range_sq_reg;
    logic [TTL_W-1:0]   start_ttl_reg;

    // Control state
    fsm_state_t         state_reg, state_next;
    logic [SEQ_W-1:0]   seq_counter_reg, seq_counter_next;
    logic               out_valid_reg, out_valid_next;
    logic               found_reg, found_next;
    logic               phase_reg, phase_next;

    // Packet being forwarded
    logic [NODE_W-1:0]  src_reg, src_next;
    logic [SEQ_W-1:0]   seq_reg, seq_next;
    logic [TTL_W-1:0]   ttl_reg, ttl_next;
    logic [HOPS_W-1:0]  hops_reg, hops_next;

    // Positions
    logic [CW-1:0]      me_x_reg, me_x_next, me_y_reg, me_y_next;
    logic [CW-1:0]      sink_x_reg, sink_x_next, sink_y_reg, sink_y_next;
    logic [CW-1:0]      c_x_reg, c_x_next, c_y_reg, c_y_next;

    // Scan bookkeeping
    logic [CNT_W-1:0]   scan_idx_reg, scan_idx_next;
    logic [CNT_W-1:0]   res_idx_reg, res_idx_next;
    logic [CNT_W-1:0]   hop_reg, hop_next;
    logic [DW-1:0]      best_reg, best_next;
    logic               range_ok_reg, range_ok_next;

    // Output register
    action_t            action_reg, action_next;
    logic [NODE_W-1:0]  next_hop_reg, next_hop_next;
    logic [NODE_W-1:0]  out_source_reg, out_source_next;
    logic [SEQ_W-1:0]   out_sequence_reg, out_sequence_next;
    logic [TTL_W-1:0]   out_ttl_reg, out_ttl_next;
    logic [HOPS_W-1:0]  out_hops_reg, out_hops_next;

    // Memory and distance unit hookup
    logic               mem_we;
    logic [IDX_W-1:0]   mem_waddr, mem_raddr;
    logic [EW-1:0]      mem_wdata, mem_rdata;
    logic [CW-1:0]      rd_x, rd_y;
    logic               rd_ctl;
    dist_tag_t          dist_in_tag, dist_out_tag;
    logic [CW-1:0]      dist_ax, dist_ay, dist_bx, dist_by;
    logic [DW-1:0]      dist_out;
    logic               dist_busy;

    logic               in_accept;
    logic               own_in_table, sink_in_table;
    logic [CNT_W-1:0]   scan_n;
    logic [CNT_W-1:0]   scan_inc;
    logic [CW-1:0]      sink_x_now, sink_y_now;
    logic               out_free;

    assign in_accept     = in_valid && in_ready;
    assign own_in_table  = 32'(own_node_reg) < MAX_NODES;
    assign sink_in_table = 32'(sink_node_reg) < MAX_NODES;
    assign scan_n        = (32'(node_count_reg) > MAX_NODES) ? CNT_W'(MAX_NODES)
                                                             : CNT_W'(node_count_reg);
    assign scan_inc      = scan_idx_reg + CNT_W'(1);
    assign out_free      = !out_valid_reg || out_ready;
    assign in_ready      = (state_reg == S_IDLE) && out_free;

    assign rd_x   = mem_rdata[CW-1:0];
    assign rd_y   = mem_rdata[2*CW-1:CW];
    assign rd_ctl = mem_rdata[2*CW];

    assign sink_x_now = sink_in_table ? rd_x : '0;
    assign sink_y_now = sink_in_table ? rd_y : '0;

    // Table writes happen only on an accepted write item
    assign mem_we    = in_accept && (req_type == REQ_WRITE) && (32'(entry_index) < MAX_NODES);
    assign mem_waddr = IDX_W'(entry_index);
    assign mem_wdata = {entry_is_controller, CW'(entry_y), CW'(entry_x)};

    ggf_node_table #(
        .DEPTH (MAX_NODES),
        .AW    (IDX_W),
        .EW    (EW)
    ) u_table (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    ggf_dist_unit #(
        .CW (CW)
    ) u_dist (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_tag   (dist_in_tag),
        .ax       (dist_ax),
        .ay       (dist_ay),
        .bx       (dist_bx),
        .by       (dist_by),
        .out_tag  (dist_out_tag),
        .out_dist (dist_out),
        .busy     (dist_busy)
    );

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_node_reg    <= '0;
            sink_node_reg   <= '0;
            own_is_sink_reg <= 1'b0;
            node_count_reg  <= '0;
            range_sq_reg    <= '0;
            start_ttl_reg   <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_OWN_NODE:    own_node_reg    <= cfg_data[NODE_W-1:0];
                CFG_SINK_NODE:   sink_node_reg   <= cfg_data[NODE_W-1:0];
                CFG_OWN_IS_SINK: own_is_sink_reg <= cfg_data[0];
                CFG_NODE_COUNT:  node_count_reg  <= cfg_data[COUNT_W-1:0];
                CFG_RANGE_SQ:    range_sq_reg    <= cfg_data[RANGE_W-1:0];
                CFG_START_TTL:   start_ttl_reg   <= cfg_data[TTL_W-1:0];
                default:         ;
            endcase
        end
    end

    // Sequencer: next state, datapath control and result compare
    always_comb
    begin
        state_next        = state_reg;
        seq_counter_next  = seq_counter_reg;
        out_valid_next    = out_valid_reg && !out_ready;
        found_next        = found_reg;
        phase_next        = phase_reg;
        src_next          = src_reg;
        seq_next          = seq_reg;
        ttl_next          = ttl_reg;
        hops_next         = hops_reg;
        me_x_next         = me_x_reg;
        me_y_next         = me_y_reg;
        sink_x_next       = sink_x_reg;
        sink_y_next       = sink_y_reg;
        c_x_next          = c_x_reg;
        c_y_next          = c_y_reg;
        scan_idx_next     = scan_idx_reg;
        res_idx_next      = res_idx_reg;
        hop_next          = hop_reg;
        best_next         = best_reg;
        range_ok_next     = range_ok_reg;
        action_next       = action_reg;
        next_hop_next     = next_hop_reg;
        out_source_next   = out_source_reg;
        out_sequence_next = out_sequence_reg;
        out_ttl_next      = out_ttl_reg;
        out_hops_next     = out_hops_reg;
        mem_raddr         = '0;
        dist_in_tag       = '0;
        dist_ax           = me_x_reg;
        dist_ay           = me_y_reg;
        dist_bx           = sink_x_reg;
        dist_by           = sink_y_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    unique case (req_type)
                        REQ_WRITE:
                        begin
                            out_valid_next    = 1'b1;
                            action_next       = ACT_WRITTEN;
                            next_hop_next     = '0;
                            out_source_next   = '0;
                            out_sequence_next = '0;
                            out_ttl_next      = '0;
                            out_hops_next     = '0;
                        end
                        REQ_RECV:
                        begin
                            src_next   = pkt_source;
                            seq_next   = pkt_sequence;
                            ttl_next   = pkt_ttl;
                            hops_next  = pkt_hops;
                            found_next = 1'b0;
                            if ((own_is_sink_reg && own_node_reg == pkt_destination)
                                || pkt_ttl == '0)
                            begin
                                out_valid_next    = 1'b1;
                                action_next       = (own_is_sink_reg
                                                     && own_node_reg == pkt_destination)
                                                    ? ACT_DELIVERED : ACT_DROP_TTL;
                                next_hop_next     = '0;
                                out_source_next   = pkt_source;
                                out_sequence_next = pkt_sequence;
                                out_ttl_next      = pkt_ttl;
                                out_hops_next     = pkt_hops;
                            end
                            else
                            begin
                                state_next = S_OWN_RD;
                            end
                        end
                        REQ_GEN:
                        begin
                            src_next         = own_node_reg;
                            seq_next         = seq_counter_reg;
                            ttl_next         = start_ttl_reg;
                            hops_next        = '0;
                            found_next       = 1'b0;
                            seq_counter_next = seq_counter_reg + SEQ_W'(1);
                            state_next       = S_OWN_RD;
                        end
                        default: ;
                    endcase
                end
            end

            S_OWN_RD:
            begin
                mem_raddr = IDX_W'(own_node_reg);
                // no hop at all when this node is the sink
                state_next = (own_node_reg == sink_node_reg) ? S_DRAIN : S_SINK_RD;
            end

            S_SINK_RD:
            begin
                mem_raddr  = IDX_W'(sink_node_reg);
                me_x_next  = own_in_table ? rd_x : '0;
                me_y_next  = own_in_table ? rd_y : '0;
                state_next = S_BASE;
            end

            S_BASE:
            begin
                // own-to-sink distance is the initial best
                sink_x_next   = sink_x_now;
                sink_y_next   = sink_y_now;
                dist_in_tag   = '{valid: 1'b1, kind: DK_BASE, skip: 1'b0};
                dist_bx       = sink_x_now;
                dist_by       = sink_y_now;
                mem_raddr     = '0;
                scan_idx_next = '0;
                res_idx_next  = '0;
                phase_next    = 1'b0;
                state_next    = (scan_n == '0) ? S_DRAIN : S_SCAN;
            end

            S_SCAN:
            begin
                if (!phase_reg)
                begin
                    // candidate to own node: range check
                    dist_in_tag = '{valid: 1'b1, kind: DK_RANGE,
                                    skip: rd_ctl
                                          || (32'(scan_idx_reg) == 32'(own_node_reg))};
                    dist_bx     = rd_x;
                    dist_by     = rd_y;
                    c_x_next    = rd_x;
                    c_y_next    = rd_y;
                    phase_next  = 1'b1;
                end
                else
                begin
                    // candidate to sink, prefetch next entry
                    dist_in_tag   = '{valid: 1'b1, kind: DK_SINK, skip: 1'b0};
                    dist_ax       = c_x_reg;
                    dist_ay       = c_y_reg;
                    mem_raddr     = scan_inc[IDX_W-1:0];
                    scan_idx_next = scan_inc;
                    phase_next    = 1'b0;
                    if (scan_inc == scan_n)
                    begin
                        state_next = S_DRAIN;
                    end
                end
            end

            S_DRAIN:
            begin
                if (!dist_busy && out_free)
                begin
                    out_valid_next    = 1'b1;
                    action_next       = found_reg ? ACT_FORWARDED : ACT_DROP_NO_HOP;
                    next_hop_next     = found_reg ? NODE_W'(hop_reg) : '0;
                    out_source_next   = src_reg;
                    out_sequence_next = seq_reg;
                    if (found_reg)
                    begin
                        out_ttl_next  = (ttl_reg == '0) ? '0 : ttl_reg - TTL_W'(1);
                        out_hops_next = (hops_reg == '1) ? '1 : hops_reg + HOPS_W'(1);
                    end
                    else
                    begin
                        out_ttl_next  = ttl_reg;
                        out_hops_next = hops_reg;
                    end
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Results leave the distance unit in issue order
        if (dist_out_tag.valid)
        begin
            case (dist_out_tag.kind)
                DK_BASE:
                begin
                    best_next = dist_out;
                end
                DK_RANGE:
                begin
                    range_ok_next = !dist_out_tag.skip
                                    && (CMP_W'(dist_out) <= CMP_W'(range_sq_reg));
                end
                DK_SINK:
                begin
                    if (range_ok_reg && dist_out < best_reg)
                    begin
                        best_next  = dist_out;
                        found_next = 1'b1;
                        hop_next   = res_idx_reg;
                    end
                    res_idx_next = res_idx_reg + CNT_W'(1);
                end
                default: ;
            endcase
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            seq_counter_reg <= '0;
            out_valid_reg   <= 1'b0;
            found_reg       <= 1'b0;
            phase_reg       <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            seq_counter_reg <= seq_counter_next;
            out_valid_reg   <= out_valid_next;
            found_reg       <= found_next;
            phase_reg       <= phase_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        src_reg          <= src_next;
        seq_reg          <= seq_next;
        ttl_reg          <= ttl_next;
        hops_reg         <= hops_next;
        me_x_reg         <= me_x_next;
        me_y_reg         <= me_y_next;
        sink_x_reg       <= sink_x_next;
        sink_y_reg       <= sink_y_next;
        c_x_reg          <= c_x_next;
        c_y_reg          <= c_y_next;
        scan_idx_reg     <= scan_idx_next;
        res_idx_reg      <= res_idx_next;
        hop_reg          <= hop_next;
        best_reg         <= best_next;
        range_ok_reg     <= range_ok_next;
        action_reg       <= action_next;
        next_hop_reg     <= next_hop_next;
        out_source_reg   <= out_source_next;
        out_sequence_reg <= out_sequence_next;
        out_ttl_reg      <= out_ttl_next;
        out_hops_reg     <= out_hops_next;
    end

    assign out_valid    = out_valid_reg;
    assign action       = action_reg;
    assign next_hop     = next_hop_reg;
    assign out_source   = out_source_reg;
    assign out_sequence = out_sequence_reg;
    assign out_ttl      = out_ttl_reg;
    assign out_hops     = out_hops_reg;

    // Distance results only arrive while a scan is running or draining
    assert property (@(posedge clk) disable iff (!rst_n)
        dist_out_tag.valid |-> (state_reg == S_SCAN || state_reg == S_DRAIN))
        else $error("distance result outside scan");

    // Completed sink distances never run ahead of issued ones
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (res_idx_reg <= scan_idx_reg))
        else $error("scan result count ahead of issue count");

    // The chosen hop is never this node itself
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DRAIN && found_reg) |-> (32'(hop_reg) != 32'(own_node_reg)))
        else $error("own node chosen as next hop");

    // Each accepted generate item advances the sequence counter by one
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && req_type == REQ_GEN)
        |=> (seq_counter_reg == $past(seq_counter_reg) + SEQ_W'(1)))
        else $error("sequence counter did not advance");

endmodule

// ----- bench/greedy_geographic_forwarder_top_test.sv -----
`timescale 1ns / 1ps

module greedy_geographic_forwarder_top_test;
    import ggf_pkg::*;

    localparam int TABLE_SIZE    = 64;
    // forwarding scans up to 64 entries; give a margin before reprogramming
    localparam int SETTLE_CYCLES = 160;
    localparam int DRAIN_LIMIT   = 20000;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_ITEMS   = 96;

    // request type the block ignores, and register indexes with no register behind them
    localparam logic [REQ_W-1:0]     REQ_UNKNOWN  = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    typedef struct packed {
        logic [REQ_W-1:0]      req;
        logic [NODE_W-1:0]     entry_index;
        logic [IN_COORD_W-1:0] entry_x;
        logic [IN_COORD_W-1:0] entry_y;
        logic                  entry_is_controller;
        logic [NODE_W-1:0]     pkt_source;
        logic [SEQ_W-1:0]      pkt_sequence;
        logic [NODE_W-1:0]     pkt_destination;
        logic [TTL_W-1:0]      pkt_ttl;
        logic [HOPS_W-1:0]     pkt_hops;
    } route_request_t;

    typedef struct packed {
        action_t           action;
        logic [NODE_W-1:0] next_hop;
        logic [NODE_W-1:0] out_source;
        logic [SEQ_W-1:0]  out_sequence;
        logic [TTL_W-1:0]  out_ttl;
        logic [HOPS_W-1:0] out_hops;
    } route_result_t;

    // Mirror of the node's routing state plus the queue of routing decisions in flight
    class route_scoreboard;
        logic [NODE_W-1:0]     own_node;
        logic [NODE_W-1:0]     sink_node;
        logic                  own_is_sink;
        logic [COUNT_W-1:0]    node_count;
        logic [RANGE_W-1:0]    range_sq;
        logic [TTL_W-1:0]      start_ttl;
        logic [IN_COORD_W-1:0] node_x [TABLE_SIZE];
        logic [IN_COORD_W-1:0] node_y [TABLE_SIZE];
        logic                  node_ctl [TABLE_SIZE];
        logic [SEQ_W-1:0]      seq_counter;
        route_result_t         pending_routes [$];
        int                    errors;
        int                    action_count [5];

        function new();
            own_node    = '0;
            sink_node   = '0;
            own_is_sink = 1'b0;
            node_count  = '0;
            range_sq    = '0;
            start_ttl   = '0;
            seq_counter = '0;
            errors      = 0;
            for (int i = 0; i < TABLE_SIZE; i++)
            begin
                node_x[i]   = '0;
                node_y[i]   = '0;
                node_ctl[i] = 1'b0;
            end
            for (int i = 0; i < 5; i++)
                action_count[i] = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_OWN_NODE:    own_node    = data[NODE_W-1:0];
                CFG_SINK_NODE:   sink_node   = data[NODE_W-1:0];
                CFG_OWN_IS_SINK: own_is_sink = data[0];
                CFG_NODE_COUNT:  node_count  = data[COUNT_W-1:0];
                CFG_RANGE_SQ:    range_sq    = data[RANGE_W-1:0];
                CFG_START_TTL:   start_ttl   = data[TTL_W-1:0];
                default: ;
            endcase
        endfunction

        function int outstanding();
            return pending_routes.size();
        endfunction

        // exact squared distance between two table entries
        function bit [63:0] node_dist(int a, int b);
            bit [63:0] dx;
            bit [63:0] dy;
            dx = 64'(node_x[a] > node_x[b] ? node_x[a] - node_x[b] : node_x[b] - node_x[a]);
            dy = 64'(node_y[a] > node_y[b] ? node_y[a] - node_y[b] : node_y[b] - node_y[a]);
            return dx * dx + dy * dy;
        endfunction

        // greedy next-hop choice and the forwarded or dropped packet
        function route_result_t forward_packet(logic [NODE_W-1:0] src, logic [SEQ_W-1:0] seq,
                                               logic [TTL_W-1:0] ttl, logic [HOPS_W-1:0] hops);
            route_result_t     r;
            bit                found;
            logic [NODE_W-1:0] hop;
            bit [63:0]         best;
            bit [63:0]         d;
            int                scan_len;
            r = '0;
            r.out_source   = src;
            r.out_sequence = seq;
            found = 1'b0;
            hop   = '0;
            if (own_node != sink_node)
            begin
                best     = node_dist(own_node, sink_node);
                scan_len = node_count > TABLE_SIZE ? TABLE_SIZE : node_count;
                for (int i = 0; i < scan_len; i++)
                begin
                    if (i == own_node || node_ctl[i])
                        continue;
                    if (node_dist(own_node, i) > range_sq)
                        continue;
                    d = node_dist(i, sink_node);
                    if (d < best)
                    begin
                        best  = d;
                        hop   = NODE_W'(i);
                        found = 1'b1;
                    end
                end
            end
            if (found)
            begin
                r.action   = ACT_FORWARDED;
                r.next_hop = hop;
                r.out_ttl  = ttl == 0 ? '0 : ttl - 1'b1;
                r.out_hops = hops == 8'hFF ? 8'hFF : hops + 1'b1;
            end
            else
            begin
                r.action   = ACT_DROP_NO_HOP;
                r.out_ttl  = ttl;
                r.out_hops = hops;
            end
            return r;
        endfunction

        // accepted request: update the mirror and queue the decision it must produce
        function void note_request(route_request_t q);
            route_result_t r;
            r = '0;
            if (q.req == REQ_WRITE)
            begin
                node_x[q.entry_index]   = q.entry_x;
                node_y[q.entry_index]   = q.entry_y;
                node_ctl[q.entry_index] = q.entry_is_controller;
                r.action = ACT_WRITTEN;
            end
            else if (q.req == REQ_RECV)
            begin
                if (own_is_sink && own_node == q.pkt_destination)
                    r.action = ACT_DELIVERED;
                else if (q.pkt_ttl == 0)
                    r.action = ACT_DROP_TTL;
                if (r.action == ACT_DELIVERED || q.pkt_ttl == 0)
                begin
                    r.out_source   = q.pkt_source;
                    r.out_sequence = q.pkt_sequence;
                    r.out_ttl      = q.pkt_ttl;
                    r.out_hops     = q.pkt_hops;
                end
                else
                    r = forward_packet(q.pkt_source, q.pkt_sequence, q.pkt_ttl, q.pkt_hops);
            end
            else if (q.req == REQ_GEN)
            begin
                r = forward_packet(own_node, seq_counter, start_ttl, '0);
                seq_counter = seq_counter + 1'b1;
            end
            else
                return;
            pending_routes.push_back(r);
        endfunction

        function void compare_field(string name, logic [15:0] want, logic [15:0] got);
            if (got !== want)
            begin
                $error("%s: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(route_result_t got);
            route_result_t want;
            if (pending_routes.size() == 0)
            begin
                $error("action: expected no item, got %0d", got.action);
                errors++;
                return;
            end
            want = pending_routes.pop_front();
            action_count[want.action]++;
            compare_field("action", 16'(want.action), 16'(got.action));
            compare_field("next_hop", 16'(want.next_hop), 16'(got.next_hop));
            compare_field("out_source", 16'(want.out_source), 16'(got.out_source));
            compare_field("out_sequence", want.out_sequence, got.out_sequence);
            compare_field("out_ttl", 16'(want.out_ttl), 16'(got.out_ttl));
            compare_field("out_hops", 16'(want.out_hops), 16'(got.out_hops));
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    logic [REQ_W-1:0]      req_type;
    logic [NODE_W-1:0]     entry_index;
    logic [IN_COORD_W-1:0] entry_x;
    logic [IN_COORD_W-1:0] entry_y;
    logic                  entry_is_controller;
    logic [NODE_W-1:0]     pkt_source;
    logic [SEQ_W-1:0]      pkt_sequence;
    logic [NODE_W-1:0]     pkt_destination;
    logic [TTL_W-1:0]      pkt_ttl;
    logic [HOPS_W-1:0]     pkt_hops;
    logic                  out_valid;
    logic                  out_ready;
    logic [ACTION_W-1:0]   action;
    logic [NODE_W-1:0]     next_hop;
    logic [NODE_W-1:0]     out_source;
    logic [SEQ_W-1:0]      out_sequence;
    logic [TTL_W-1:0]      out_ttl;
    logic [HOPS_W-1:0]     out_hops;
    logic                  cfg_write;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    route_scoreboard board;
    route_result_t   seen_result;
    bit              no_gaps;
    int              settings_done;

    greedy_geographic_forwarder_top u_dut (
        .clk                 (clk),
        .rst_n               (rst_n),
        .in_valid            (in_valid),
        .in_ready            (in_ready),
        .req_type            (req_type),
        .entry_index         (entry_index),
        .entry_x             (entry_x),
        .entry_y             (entry_y),
        .entry_is_controller (entry_is_controller),
        .pkt_source          (pkt_source),
        .pkt_sequence        (pkt_sequence),
        .pkt_destination     (pkt_destination),
        .pkt_ttl             (pkt_ttl),
        .pkt_hops            (pkt_hops),
        .out_valid           (out_valid),
        .out_ready           (out_ready),
        .action              (action),
        .next_hop            (next_hop),
        .out_source          (out_source),
        .out_sequence        (out_sequence),
        .out_ttl             (out_ttl),
        .out_hops            (out_hops),
        .cfg_write           (cfg_write),
        .cfg_index           (cfg_index),
        .cfg_data            (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Hard stop if the block hangs
    initial
    begin
        #10_000_000;
        $display("greedy_geographic_forwarder_top_test: errors");
        $finish;
    end

    // Result side: random back-pressure, none while no_gaps is set
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            out_ready <= no_gaps || ($urandom_range(99) >= 20);
        end
    end

    // Result monitor
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            seen_result.action       = action_t'(action);
            seen_result.next_hop     = next_hop;
            seen_result.out_source   = out_source;
            seen_result.out_sequence = out_sequence;
            seen_result.out_ttl      = out_ttl;
            seen_result.out_hops     = out_hops;
            board.check_result(seen_result);
        end
    end

    // value with random bits above the register width
    function automatic logic [CFG_DATA_W-1:0] with_junk(logic [CFG_DATA_W-1:0] value,
                                                        int width);
        logic [63:0] noise;
        noise = {$urandom, $urandom};
        return (noise[CFG_DATA_W-1:0] << width) | value;
    endfunction

    function automatic route_request_t random_fill();
        route_request_t r;
        logic [127:0]   noise;
        noise = {$urandom, $urandom, $urandom, $urandom};
        r = noise[$bits(route_request_t)-1:0];
        return r;
    endfunction

    function automatic route_request_t write_req(int idx, int x, int y, bit ctl);
        route_request_t r;
        r = random_fill();
        r.req                 = REQ_WRITE;
        r.entry_index         = NODE_W'(idx);
        r.entry_x             = IN_COORD_W'(x);
        r.entry_y             = IN_COORD_W'(y);
        r.entry_is_controller = ctl;
        return r;
    endfunction

    function automatic route_request_t recv_req(int src, int seq, int dest, int ttl, int hops);
        route_request_t r;
        r = random_fill();
        r.req             = REQ_RECV;
        r.pkt_source      = NODE_W'(src);
        r.pkt_sequence    = SEQ_W'(seq);
        r.pkt_destination = NODE_W'(dest);
        r.pkt_ttl         = TTL_W'(ttl);
        r.pkt_hops        = HOPS_W'(hops);
        return r;
    endfunction

    function automatic route_request_t typed_req(logic [REQ_W-1:0] kind);
        route_request_t r;
        r = random_fill();
        r.req = kind;
        return r;
    endfunction

    // mostly clustered writes, packets and generate requests, with a little noise
    function automatic route_request_t random_request();
        route_request_t r;
        int             pick;
        int             k;
        r    = random_fill();
        pick = $urandom_range(99);
        k    = $urandom_range(99);
        if (pick < 20)
        begin
            r.req = REQ_WRITE;
            if (k < 80)
            begin
                r.entry_x = IN_COORD_W'($urandom_range(255));
                r.entry_y = IN_COORD_W'($urandom_range(255));
            end
            else if (k >= 90)
            begin
                r.entry_x = $urandom_range(1) ? 16'hFFFF : 16'h0000;
                r.entry_y = $urandom_range(1) ? 16'hFFFF : 16'h0000;
            end
            r.entry_is_controller = $urandom_range(99) < 20;
        end
        else if (pick < 65)
        begin
            r.req = REQ_RECV;
            if ($urandom_range(99) < 30)
                r.pkt_destination = board.own_node;
            if (k < 10)
                r.pkt_ttl = 8'd0;
            else if (k < 20)
                r.pkt_ttl = 8'd1;
            else if (k < 25)
                r.pkt_ttl = 8'hFF;
            k = $urandom_range(99);
            if (k < 10)
                r.pkt_hops = 8'hFF;
            else if (k < 15)
                r.pkt_hops = 8'hFE;
        end
        else if (pick < 95)
            r.req = REQ_GEN;
        else
            r.req = REQ_UNKNOWN;
        return r;
    endfunction

    task automatic send_item(route_request_t r);
        while (!no_gaps && $urandom_range(99) < 20)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid            <= 1'b1;
        req_type            <= r.req;
        entry_index         <= r.entry_index;
        entry_x             <= r.entry_x;
        entry_y             <= r.entry_y;
        entry_is_controller <= r.entry_is_controller;
        pkt_source          <= r.pkt_source;
        pkt_sequence        <= r.pkt_sequence;
        pkt_destination     <= r.pkt_destination;
        pkt_ttl             <= r.pkt_ttl;
        pkt_hops            <= r.pkt_hops;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        board.note_request(r);
        @(negedge clk);
    endtask

    // stop sending and let every outstanding decision come back
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (board.outstanding() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        board.set_reg(idx, data);
        @(negedge clk);
    endtask

    task automatic program_node(int own, int sink, bit is_sink, int count,
                                logic [RANGE_W-1:0] range_sq, int ttl);
        write_reg(CFG_OWN_NODE, with_junk(CFG_DATA_W'(own), NODE_W));
        write_reg(CFG_SINK_NODE, with_junk(CFG_DATA_W'(sink), NODE_W));
        write_reg(CFG_OWN_IS_SINK, with_junk(CFG_DATA_W'(is_sink), 1));
        write_reg(CFG_NODE_COUNT, with_junk(CFG_DATA_W'(count), COUNT_W));
        write_reg(CFG_RANGE_SQ, range_sq);
        write_reg(CFG_START_TTL, with_junk(CFG_DATA_W'(ttl), TTL_W));
        cfg_write <= 1'b0;
        settings_done++;
    endtask

    task automatic random_setup();
        int                 own;
        int                 sink;
        int                 count;
        int                 ttl;
        logic [RANGE_W-1:0] range_sq;
        own   = $urandom_range(TABLE_SIZE - 1);
        sink  = $urandom_range(9) == 0 ? own : $urandom_range(TABLE_SIZE - 1);
        case ($urandom_range(4))
            0:       count = TABLE_SIZE;
            1:       count = $urandom_range(127, TABLE_SIZE + 1);
            2:       count = $urandom_range(8);
            default: count = $urandom_range(TABLE_SIZE, 40);
        endcase
        case ($urandom_range(4))
            0:       range_sq = '0;
            1:       range_sq = '1;
            2:       range_sq = RANGE_W'({$urandom, $urandom});
            default: range_sq = RANGE_W'($urandom_range(60000, 2000));
        endcase
        case ($urandom_range(3))
            0:       ttl = 0;
            1:       ttl = 255;
            default: ttl = $urandom_range(255);
        endcase
        program_node(own, sink, $urandom_range(1), count, range_sq, ttl);
    endtask

    initial
    begin
        rst_n               = 1'b0;
        in_valid            = 1'b0;
        req_type            = REQ_WRITE;
        entry_index         = '0;
        entry_x             = '0;
        entry_y             = '0;
        entry_is_controller = 1'b0;
        pkt_source          = '0;
        pkt_sequence        = '0;
        pkt_destination     = '0;
        pkt_ttl             = '0;
        pkt_hops            = '0;
        cfg_write           = 1'b0;
        cfg_index           = CFG_OWN_NODE;
        cfg_data            = '0;
        no_gaps             = 1'b0;
        settings_done       = 0;
        board               = new();

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Load every table entry so no scan ever touches an unwritten one
        for (int i = 0; i < TABLE_SIZE; i++)
            send_item(write_req(i, $urandom_range(255), $urandom_range(255),
                                $urandom_range(99) < 20));
        wait_idle();

        // Own node far from a controller sink, full range, generated TTL of zero
        write_reg(CFG_SPARE_LO, with_junk(CFG_DATA_W'(0), 0));
        write_reg(CFG_SPARE_HI, with_junk(CFG_DATA_W'(0), 0));
        program_node(5, 40, 1'b0, TABLE_SIZE, '1, 0);
        send_item(write_req(5, 0, 0, 1'b0));
        send_item(write_req(40, 16'hFFFF, 16'hFFFF, 1'b1));
        send_item(recv_req(1, 100, 9, 0, 3));
        send_item(recv_req(2, 200, 9, 1, 255));
        send_item(recv_req(3, 300, 9, 255, 254));
        send_item(recv_req(4, 400, 5, 9, 0));
        send_item(typed_req(REQ_GEN));
        send_item(typed_req(REQ_GEN));
        send_item(typed_req(REQ_UNKNOWN));
        send_item(recv_req(63, 16'hFFFF, 9, 2, 0));
        wait_idle();

        // This node is the sink: delivery, own-is-sink no hop, oversized count, zero range
        program_node(7, 7, 1'b1, 127, '0, 255);
        send_item(recv_req(0, 0, 7, 0, 0));
        send_item(recv_req(63, 16'hFFFF, 7, 255, 255));
        send_item(recv_req(8, 11, 8, 3, 1));
        send_item(recv_req(9, 12, 8, 0, 1));
        send_item(typed_req(REQ_GEN));
        wait_idle();

        // Empty scan
        program_node(63, 0, 1'b0, 0, '1, 128);
        send_item(typed_req(REQ_GEN));
        send_item(recv_req(10, 13, 1, 1, 0));
        wait_idle();

        // Highest own index with a scan clipped to the table size
        program_node(63, 0, 1'b0, 127, '1, 1);
        send_item(typed_req(REQ_GEN));
        send_item(recv_req(11, 14, 63, 2, 0));

        // Random phases, one of them with no idling on either side
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            wait_idle();
            random_setup();
            no_gaps = (p == 3);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (p == 5 && n == PHASE_ITEMS / 2)
                begin
                    while (board.outstanding() != 0)
                    begin
                        in_valid <= 1'b0;
                        @(negedge clk);
                    end
                end
                send_item(random_request());
            end
            no_gaps = 1'b0;
        end
        in_valid <= 1'b0;

        // Drain, bounded
        for (int w = 0; w < DRAIN_LIMIT && board.outstanding() != 0; w++)
            @(negedge clk);
        if (board.outstanding() != 0)
        begin
            $error("out_valid: expected %0d more items, got none", board.outstanding());
            board.errors++;
        end
        repeat (SETTLE_CYCLES) @(negedge clk);

        $display("Covered %0d register settings; results: %0d forwarded, %0d delivered,",
                 settings_done, board.action_count[ACT_FORWARDED],
                 board.action_count[ACT_DELIVERED]);
        $display("%0d dropped on TTL, %0d dropped with no hop, %0d table writes.",
                 board.action_count[ACT_DROP_TTL], board.action_count[ACT_DROP_NO_HOP],
                 board.action_count[ACT_WRITTEN]);
        if (board.errors == 0)
            $display("greedy_geographic_forwarder_top_test: clean");
        else
            $display("greedy_geographic_forwarder_top_test: errors");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/ggf_pkg.sv
rtl/ggf_node_table.sv
rtl/ggf_dist_unit.sv
rtl/greedy_geographic_forwarder_top.sv
bench/greedy_geographic_forwarder_top_test.sv
